/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication into the next cycle
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* rtl/alu64_pkg.sv */
// ----------------------------------------------------------------------------
// alu64_pkg
// Types and constants shared by the checked 64-bit ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package alu64_pkg;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int MUL_STEPS = 4;

    localparam logic [63:0] SIGN_MASK64 = 64'h8000_0000_0000_0000;

    localparam logic [1:0] ST_INT        = 2'd0;
    localparam logic [1:0] ST_FLOAT      = 2'd1;
    localparam logic [1:0] ST_DIVZERO    = 2'd2;
    localparam logic [1:0] ST_NOTHANDLED = 2'd3;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_SHL = 4'd5,
        OP_SHR = 4'd6,
        OP_POW = 4'd7,
        OP_AND = 4'd8,
        OP_OR  = 4'd9,
        OP_XOR = 4'd10,
        OP_NOT = 4'd11,
        OP_BAD = 4'd12
    } op_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] a;
        logic [63:0] b;
        logic        a_neg;
        logic        b_neg;
        logic        a_zero;
        logic        b_zero;
        logic        b_big;
    } work_t;

    function automatic logic [63:0] mag(input logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

endpackage
`default_nettype wire

/* rtl/alu64_front.sv */
// ----------------------------------------------------------------------------
// alu64_front
// Accepts request beats, decodes the operation and pushes work to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module alu64_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire alu64_pkg::req_t req,
    output logic                 q_push,
    output alu64_pkg::work_t     q_item,
    input  wire logic            q_full
);
    import alu64_pkg::*;

    logic  hold_valid_reg;
    work_t hold_reg;

    function automatic work_t classify(input req_t r);
        work_t w;
        w.a      = r.operand_a;
        w.b      = r.operand_b;
        w.a_neg  = r.operand_a[63];
        w.b_neg  = r.operand_b[63];
        w.a_zero = (r.operand_a == 64'sd0);
        w.b_zero = (r.operand_b == 64'sd0);
        w.b_big  = !r.operand_b[63] && (r.operand_b[62:6] != 57'd0);
        w.op     = (r.kind > OP_NOT) ? OP_BAD : op_t'(r.kind);
        return w;
    endfunction

    assign q_push    = hold_valid_reg && !q_full;
    assign req_stall = hold_valid_reg && q_full;
    assign q_item    = hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            hold_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            hold_reg <= classify(req);
        end
    end

endmodule
`default_nettype wire

/* rtl/alu64_fifo.sv */
// ----------------------------------------------------------------------------
// alu64_fifo
// Short work queue between the front and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none
module alu64_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire alu64_pkg::work_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output alu64_pkg::work_t      head
);
    import alu64_pkg::*;

    work_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    function automatic logic [Q_PTR_W-1:0] bump(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/alu64_mul.sv */
// ----------------------------------------------------------------------------
// alu64_mul
// Unsigned 64x64 to 128-bit multiplier from four 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none
module alu64_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    input  wire logic [63:0] y,
    output logic             done,
    output logic [127:0]     prod
);
    import alu64_pkg::*;

    localparam int CNT_W = $clog2(MUL_STEPS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [63:0]      x_reg;
    logic [63:0]      y_reg;
    logic [63:0]      pp_reg;
    logic [1:0]       sh_reg;
    logic [127:0]     acc_reg;
    logic [31:0]      xp;
    logic [31:0]      yp;

    assign xp   = cnt_reg[0] ? x_reg[63:32] : x_reg[31:0];
    assign yp   = cnt_reg[1] ? y_reg[63:32] : y_reg[31:0];
    assign done = done_reg;
    assign prod = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < CNT_W'(MUL_STEPS))
            begin
                pp_reg <= xp * yp;
                sh_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
            if (cnt_reg != '0)
            begin
                acc_reg <= acc_reg + ({64'd0, pp_reg} << {sh_reg, 5'd0});
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/alu64_back.sv */
// ----------------------------------------------------------------------------
// alu64_back
// Execution back end: combinational ops, sequenced multiply, divide and power.
// ----------------------------------------------------------------------------
`default_nettype none
module alu64_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire alu64_pkg::work_t q_head,
    output logic                  q_pop,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output alu64_pkg::rsp_t       rsp
);
    import alu64_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_DIVF, S_POW, S_PW, S_PM, S_PSH, S_PSW, S_PSM, S_FIN
    } state_t;

    state_t       state_reg;
    work_t        w_reg;
    logic         rsp_valid_reg;
    rsp_t         rsp_reg;
    logic [63:0]  res_val_reg;
    logic [1:0]   res_st_reg;
    logic         mul_start_reg;
    logic [63:0]  mul_x_reg;
    logic [63:0]  mul_y_reg;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic [63:0]  quo_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  den_reg;
    logic [5:0]   cnt_reg;
    logic [63:0]  e_reg;
    logic [63:0]  wbase_reg;
    logic [63:0]  wres_reg;
    logic [63:0]  mbase_reg;
    logic [63:0]  mres_reg;
    logic         over_reg;

    logic [63:0]  s_val;
    logic [1:0]   s_st;
    logic [63:0]  rem_sh;
    logic         sub_ok;
    logic         p_over;
    logic [63:0]  p_lo;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rem_sh = {rem_reg[62:0], quo_reg[63]};
    assign sub_ok = (rem_sh >= den_reg);
    assign p_lo   = mul_prod[63:0];
    assign p_over = (mul_prod[127:64] != 64'd0) || (p_lo[63] && (p_lo[62:0] != 63'd0));

    function automatic logic fits(input logic [63:0] m, input logic neg);
        return !m[63] || (m == SIGN_MASK64 && neg);
    endfunction

    always_comb
    begin
        s_val = 64'd0;
        s_st  = ST_INT;
        case (q_head.op)
            OP_ADD:
            begin
                s_val = q_head.a + q_head.b;
                if ((((q_head.a ^ s_val) & (q_head.b ^ s_val)) & SIGN_MASK64) != 64'd0)
                begin
                    s_st = ST_FLOAT;
                end
            end
            OP_SUB:
            begin
                s_val = q_head.a - q_head.b;
                if ((((q_head.a ^ q_head.b) & (q_head.a ^ s_val)) & SIGN_MASK64) != 64'd0)
                begin
                    s_st = ST_FLOAT;
                end
            end
            OP_SHL:
            begin
                if (q_head.b_neg)
                begin
                    s_st = ST_NOTHANDLED;
                end
                else if (!q_head.b_big)
                begin
                    s_val = q_head.a << q_head.b[5:0];
                end
            end
            OP_SHR:
            begin
                if (q_head.b_neg)
                begin
                    s_st = ST_NOTHANDLED;
                end
                else if (q_head.b_big)
                begin
                    s_val = {64{q_head.a_neg}};
                end
                else
                begin
                    s_val = 64'($signed(q_head.a) >>> q_head.b[5:0]);
                end
            end
            OP_AND: s_val = q_head.a & q_head.b;
            OP_OR:  s_val = q_head.a | q_head.b;
            OP_XOR: s_val = q_head.a ^ q_head.b;
            OP_NOT: s_val = ~q_head.a;
            default: s_st = ST_NOTHANDLED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            mul_start_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_FIN))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        w_reg <= q_head;
                        case (q_head.op)
                            OP_MUL:
                            begin
                                mul_x_reg     <= mag(q_head.a);
                                mul_y_reg     <= mag(q_head.b);
                                mul_start_reg <= 1'b1;
                                state_reg     <= S_MUL;
                            end
                            OP_DIV, OP_MOD:
                            begin
                                if (q_head.b_zero)
                                begin
                                    res_val_reg <= 64'd0;
                                    res_st_reg  <= ST_DIVZERO;
                                    state_reg   <= S_FIN;
                                end
                                else
                                begin
                                    quo_reg   <= mag(q_head.a);
                                    den_reg   <= mag(q_head.b);
                                    rem_reg   <= 64'd0;
                                    cnt_reg   <= 6'd0;
                                    state_reg <= S_DIV;
                                end
                            end
                            OP_POW:
                            begin
                                if (q_head.b_neg)
                                begin
                                    res_val_reg <= 64'd0;
                                    res_st_reg  <= ST_NOTHANDLED;
                                    state_reg   <= S_FIN;
                                end
                                else if (q_head.a_zero)
                                begin
                                    res_val_reg <= {63'd0, q_head.b_zero};
                                    res_st_reg  <= ST_INT;
                                    state_reg   <= S_FIN;
                                end
                                else
                                begin
                                    e_reg     <= q_head.b;
                                    wbase_reg <= q_head.a;
                                    wres_reg  <= 64'd1;
                                    mbase_reg <= mag(q_head.a);
                                    mres_reg  <= 64'd1;
                                    over_reg  <= 1'b0;
                                    state_reg <= S_POW;
                                end
                            end
                            default:
                            begin
                                res_val_reg <= s_val;
                                res_st_reg  <= s_st;
                                state_reg   <= S_FIN;
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        res_val_reg <= (w_reg.a_neg ^ w_reg.b_neg) ? (64'd0 - p_lo) : p_lo;
                        res_st_reg  <= ((mul_prod[127:64] != 64'd0) ||
                                        !fits(p_lo, w_reg.a_neg ^ w_reg.b_neg))
                                       ? ST_FLOAT : ST_INT;
                        state_reg   <= S_FIN;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= sub_ok ? (rem_sh - den_reg) : rem_sh;
                    quo_reg <= {quo_reg[62:0], sub_ok};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= S_DIVF;
                    end
                end
                S_DIVF:
                begin
                    if (w_reg.op == OP_DIV)
                    begin
                        res_val_reg <= (w_reg.a_neg ^ w_reg.b_neg) ? (64'd0 - quo_reg) : quo_reg;
                        res_st_reg  <= ((rem_reg != 64'd0) ||
                                        !fits(quo_reg, w_reg.a_neg ^ w_reg.b_neg))
                                       ? ST_FLOAT : ST_INT;
                    end
                    else
                    begin
                        res_val_reg <= w_reg.a_neg ? (64'd0 - rem_reg) : rem_reg;
                        res_st_reg  <= ST_INT;
                    end
                    state_reg <= S_FIN;
                end
                S_POW:
                begin
                    if (e_reg == 64'd0)
                    begin
                        res_val_reg <= wres_reg;
                        res_st_reg  <= (over_reg || !fits(mres_reg, w_reg.a_neg && w_reg.b[0]))
                                       ? ST_FLOAT : ST_INT;
                        state_reg   <= S_FIN;
                    end
                    else if (e_reg[0])
                    begin
                        mul_x_reg     <= wres_reg;
                        mul_y_reg     <= wbase_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_PW;
                    end
                    else
                    begin
                        state_reg <= S_PSH;
                    end
                end
                S_PW:
                begin
                    if (mul_done)
                    begin
                        wres_reg <= p_lo;
                        if (!over_reg)
                        begin
                            mul_x_reg     <= mres_reg;
                            mul_y_reg     <= mbase_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_PM;
                        end
                        else
                        begin
                            state_reg <= S_PSH;
                        end
                    end
                end
                S_PM:
                begin
                    if (mul_done)
                    begin
                        if (p_over)
                        begin
                            over_reg <= 1'b1;
                        end
                        else
                        begin
                            mres_reg <= p_lo;
                        end
                        state_reg <= S_PSH;
                    end
                end
                S_PSH:
                begin
                    e_reg <= e_reg >> 1;
                    if (e_reg[63:1] != 63'd0)
                    begin
                        mul_x_reg     <= wbase_reg;
                        mul_y_reg     <= wbase_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_PSW;
                    end
                    else
                    begin
                        state_reg <= S_POW;
                    end
                end
                S_PSW:
                begin
                    if (mul_done)
                    begin
                        wbase_reg <= p_lo;
                        if (!over_reg)
                        begin
                            mul_x_reg     <= mbase_reg;
                            mul_y_reg     <= mbase_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_PSM;
                        end
                        else
                        begin
                            state_reg <= S_POW;
                        end
                    end
                end
                S_PSM:
                begin
                    if (mul_done)
                    begin
                        if (p_over)
                        begin
                            over_reg <= 1'b1;
                        end
                        else
                        begin
                            mbase_reg <= p_lo;
                        end
                        state_reg <= S_POW;
                    end
                end
                S_FIN:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg.value  <= res_val_reg;
                        rsp_reg.status <= res_st_reg;
                        rsp_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    alu64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .x     (mul_x_reg),
        .y     (mul_y_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

endmodule
`default_nettype wire

/* rtl/int64_alu_overflow_checked_unit.sv */
// Multiply, divide/mod and power are sequenced in the back end; power uses the shared
// four-step 32x32 multiplier for up to four products per exponent bit. The back end runs
// one item at a time while the front and a two-entry queue keep taking beats until the
// queue is full and req_stall is raised. Reset clears all control state at once.
// ----------------------------------------------------------------------------
// int64_alu_overflow_checked_unit
// Signed 64-bit ALU with exact overflow, divide-by-zero and unhandled status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module int64_alu_overflow_checked_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire alu64_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output alu64_pkg::rsp_t      rsp
);
    import alu64_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    work_t q_item;
    work_t q_head;
    logic  rsp_err;

    assign rsp_err = rsp_valid && (rsp.status == ST_DIVZERO || rsp.status == ST_NOTHANDLED);

    alu64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_push    (q_push),
        .q_item    (q_item),
        .q_full    (q_full)
    );

    alu64_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    alu64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `ASSERT_SAME(a_zero_on_error, rsp_err, rsp.value == 64'sd0)
    `ASSERT_SAME(a_no_push_full, q_push, !q_full)
    `ASSERT_SAME(a_no_pop_empty, q_pop, q_valid)
    `ASSERT_NEXT(a_pop_fills, q_pop && !q_push && !q_full, !q_full)

endmodule
`default_nettype wire
